// ===== src/free_list_allocator_macros.svh =====
// Assertion macros used by the allocator back end.
`ifndef FREE_LIST_ALLOCATOR_MACROS_SVH
`define FREE_LIST_ALLOCATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define FLA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FLA_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FLA_ASSERT(label, clk, rst, prop, msg)
`define FLA_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== src/fla_pkg.sv =====
// Package with the allocator's constants, status codes and shared types.
package fla_pkg;
  localparam int ARENA_BYTES_DEF  = 65536;
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int MAX_RECORDS_DEF  = 64;
  localparam int HEADER_BYTES_DEF = 16;
  localparam int NODE_BYTES_DEF   = 16;
  localparam int MIN_ALIGN_LOG2   = 3;
  localparam int MAX_ALIGN_LOG2   = 12;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_BAD      = 3'd2;
  localparam logic [2:0] ST_NOTALLOC = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Classified command handed from the front end to the back end.
  typedef enum logic [1:0] {
    CMD_ALLOC,
    CMD_FREE,
    CMD_REPLY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [16:0] size;
    logic [3:0]  align_log2;
    logic [15:0] addr;
    logic [2:0]  status;
  } cmd_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_REC_SCAN,
    S_REC_WAIT,
    S_SHIFT,
    S_SHIFT_WR,
    S_PLACE,
    S_COMMIT,
    S_RESULT
  } be_state_t;
endpackage

// ===== src/fla_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/fla_front.sv =====
// Front end: accepts request words, rejects malformed ones, queues commands.
module fla_front
  import fla_pkg::*;
#(
  parameter int NODE_BYTES = NODE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [16:0] request_size,
  input  logic [3:0]  align_log2,
  input  logic [15:0] free_address,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_take
);
  localparam int QD = 2;
  cmd_t q [QD];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t c;

  always_comb begin
    c = '0;
    c.size = request_size;
    c.align_log2 = align_log2;
    c.addr = free_address;
    c.status = ST_OK;
    if (opcode == OP_ALLOC) begin
      if (align_log2 < 4'(MIN_ALIGN_LOG2) || align_log2 > 4'(MAX_ALIGN_LOG2) ||
          request_size < 17'(NODE_BYTES)) begin
        c.kind = CMD_REPLY;
        c.status = ST_BAD;
      end else begin
        c.kind = CMD_ALLOC;
      end
    end else if (free_address == '0) begin
      c.kind = CMD_REPLY;
    end else begin
      c.kind = CMD_FREE;
    end
  end

  assign full = (cnt == 2'(QD));
  assign cmd_valid = (cnt != '0);
  assign cmd = q[rp];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      q[wp] <= c;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push && !full) begin
        wp <= ~wp;
      end
      if (cmd_take && cmd_valid) begin
        rp <= ~rp;
      end
      cnt <= cnt + 2'(push && !full) - 2'(cmd_take && cmd_valid);
    end
  end
endmodule

// ===== src/fla_back.sv =====
// Back end: walks the segment and record tables and applies each command.
module fla_back
  import fla_pkg::*;
#(
  parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int NODE_BYTES   = NODE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fit_policy,
  input  logic        cmd_valid,
  input  cmd_t        cmd,
  output logic        cmd_take,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [2:0]  res_status,
  output logic [15:0] res_addr,
  output logic [16:0] res_used,
  output logic [16:0] res_peak,
  output logic [6:0]  res_count
);
  localparam int SW = $clog2(MAX_SEGMENTS);
  localparam int RW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int RCW = $clog2(MAX_RECORDS + 1);
  localparam int AW = $clog2(ARENA_BYTES + 1);
  localparam int XW = AW + 2;

  be_state_t state, state_next;
  cmd_t      cur;
  logic      is_free;

  logic [CW-1:0] seg_cnt;
  logic [AW-1:0] used, peak;
  logic [MAX_RECORDS-1:0] rvalid;

  // Status and address of the word in progress, copied out when it is done.
  logic [2:0]  wk_status;
  logic [15:0] wk_addr;

  // Segment memory holds {start, length}.
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [2*AW-1:0] s_wdata, s_rdata;
  logic [AW-1:0] rd_start, rd_len;

  logic          r_we;
  logic [RW-1:0] r_waddr, r_raddr;
  logic [16+2*AW-1:0] r_wdata, r_rdata;
  logic [15:0]   rr_data;
  logic [AW-1:0] rr_bs, rr_bl;

  logic [CW-1:0] idx;
  logic [RCW-1:0] ridx;
  logic          have;
  logic [SW-1:0] found;
  logic [AW-1:0] f_start, f_len, best_left;
  logic [AW-1:0] prev_start, prev_len;
  logic          have_prev;
  logic [RW-1:0] slot;
  logic [AW-1:0] bs, bl;
  logic [CW-1:0] pos;
  logic          mnext, mprev;
  logic [AW-1:0] nxt_len;
  logic          shift_up;
  logic [CW-1:0] sh;
  logic [AW-1:0] mask, pad, need;
  logic [XW-1:0] pad_sum;
  logic          fits;
  logic [AW-1:0] left;

  fla_ram #(.WIDTH(2*AW), .DEPTH(MAX_SEGMENTS)) u_seg (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata));
  fla_ram #(.WIDTH(16+2*AW), .DEPTH(MAX_RECORDS)) u_rec (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .raddr(r_raddr), .rdata(r_rdata));

  assign rd_start = s_rdata[2*AW-1:AW];
  assign rd_len   = s_rdata[AW-1:0];
  assign rr_data  = r_rdata[16+2*AW-1:2*AW];
  assign rr_bs    = r_rdata[2*AW-1:AW];
  assign rr_bl    = r_rdata[AW-1:0];
  assign is_free  = (cur.kind == CMD_FREE);

  function automatic logic [AW-1:0] pad_of(input logic [AW-1:0] st);
    logic [XW-1:0] ps;
    ps = XW'(st) + XW'(HEADER_BYTES) + XW'(mask);
    return AW'((ps & ~XW'(mask)) - XW'(st));
  endfunction

  always_comb begin
    mask = AW'((1 << cur.align_log2) - 1);
    pad_sum = XW'(rd_start) + XW'(HEADER_BYTES) + XW'(mask);
    pad = AW'((pad_sum & ~XW'(mask)) - XW'(rd_start));
    need = AW'(XW'(cur.size) + XW'(pad));
    fits = (XW'(rd_len) >= XW'(cur.size) + XW'(pad));
    left = rd_len - need;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Combinational control: state transitions and memory ports.
  always_comb begin
    state_next = state;
    cmd_take = 1'b0;
    s_we = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    s_raddr = SW'(idx);
    r_we = 1'b0;
    r_waddr = slot;
    r_wdata = '0;
    r_raddr = RW'(ridx);
    unique case (state)
      S_CLEAR: begin
        // The whole arena starts out as one free segment.
        s_we = 1'b1;
        s_waddr = '0;
        s_wdata = {AW'(0), AW'(ARENA_BYTES)};
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_take = 1'b1;
          state_next = (cmd.kind == CMD_REPLY) ? S_RESULT :
                       (cmd.kind == CMD_ALLOC) ? S_SCAN_WAIT : S_REC_WAIT;
        end
        s_raddr = '0;
        r_raddr = '0;
      end
      S_SCAN_WAIT: state_next = S_SCAN;
      S_SCAN: begin
        s_raddr = SW'(idx + 1'b1);
        if (is_free) begin
          if (idx >= seg_cnt || rd_start >= bs) begin
            state_next = S_COMMIT;
          end
        end else if (idx >= seg_cnt ||
                     (have && fit_policy == 1'b0)) begin
          state_next = S_REC_SCAN;
        end
      end
      S_REC_WAIT: state_next = S_REC_SCAN;
      S_REC_SCAN: begin
        r_raddr = RW'(ridx + 1'b1);
        if (is_free) begin
          if (ridx >= RCW'(MAX_RECORDS)) begin
            state_next = S_RESULT;
          end else if (rvalid[RW'(ridx)] && rr_data == cur.addr) begin
            state_next = S_SCAN_WAIT;
          end
        end else if (!have || ridx >= RCW'(MAX_RECORDS) || !rvalid[RW'(ridx)]) begin
          state_next = (!have || ridx >= RCW'(MAX_RECORDS)) ? S_RESULT : S_COMMIT;
        end
      end
      S_COMMIT: begin
        state_next = S_RESULT;
        if (!is_free) begin
          r_we = 1'b1;
          r_wdata = {16'(f_start + pad_of(f_start)), f_start, bl};
          if (best_left > AW'(NODE_BYTES)) begin
            s_we = 1'b1;
            s_waddr = found;
            s_wdata = {AW'(f_start + bl), best_left};
          end else if (CW'(found) + 1'b1 < seg_cnt) begin
            state_next = S_SHIFT;
          end
        end else if (mprev && !mnext) begin
          s_we = 1'b1;
          s_waddr = SW'(pos - 1'b1);
          s_wdata = {prev_start, AW'(prev_len + bl)};
        end else if (mnext && !mprev) begin
          s_we = 1'b1;
          s_waddr = SW'(pos);
          s_wdata = {bs, AW'(nxt_len + bl)};
        end else if (mprev && mnext) begin
          s_we = 1'b1;
          s_waddr = SW'(pos - 1'b1);
          s_wdata = {prev_start, AW'(prev_len + bl + nxt_len)};
          if (pos + 1'b1 < seg_cnt) begin
            state_next = S_SHIFT;
          end
        end else if (seg_cnt < CW'(MAX_SEGMENTS)) begin
          if (pos == seg_cnt) begin
            s_we = 1'b1;
            s_waddr = SW'(pos);
            s_wdata = {bs, bl};
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        s_raddr = shift_up ? SW'(sh) : SW'(sh + 1'b1);
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        s_we = 1'b1;
        s_wdata = s_rdata;
        if (shift_up) begin
          s_waddr = SW'(sh + 1'b1);
          state_next = (sh == pos) ? S_PLACE : S_SHIFT;
        end else begin
          s_waddr = SW'(sh);
          state_next = (sh + 1'b1 < seg_cnt) ? S_SHIFT : S_RESULT;
        end
      end
      S_PLACE: begin
        s_we = 1'b1;
        s_waddr = SW'(pos);
        s_wdata = {bs, bl};
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers for command capture, scans, commit and result.
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_cnt <= CW'(1);
      used <= '0;
      peak <= '0;
      rvalid <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready && state != S_RESULT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cur <= cmd;
            idx <= '0;
            ridx <= '0;
            have <= 1'b0;
            have_prev <= 1'b0;
            wk_status <= cmd.status;
            wk_addr <= '0;
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          if (is_free) begin
            if (idx < seg_cnt && rd_start < bs) begin
              prev_start <= rd_start;
              prev_len <= rd_len;
              have_prev <= 1'b1;
            end else begin
              pos <= idx;
              nxt_len <= rd_len;
              mnext <= (idx < seg_cnt) && (AW'(bs + bl) == rd_start);
              mprev <= have_prev && (AW'(prev_start + prev_len) == bs);
            end
          end else if (idx < seg_cnt && fits &&
                       (!have || (fit_policy && left < best_left))) begin
            if (!(have && fit_policy == 1'b0)) begin
              have <= 1'b1;
              found <= SW'(idx);
              f_start <= rd_start;
              f_len <= rd_len;
              best_left <= left;
            end
          end
          if (!is_free && (idx >= seg_cnt || (have && !fit_policy))) begin
            if (!have) begin
              wk_status <= ST_NOFIT;
            end
          end
        end
        S_REC_SCAN: begin
          ridx <= ridx + 1'b1;
          if (is_free) begin
            if (ridx >= RCW'(MAX_RECORDS)) begin
              wk_status <= ST_NOTALLOC;
            end else if (rvalid[RW'(ridx)] && rr_data == cur.addr) begin
              slot <= RW'(ridx);
              bs <= rr_bs;
              bl <= rr_bl;
              idx <= '0;
            end
          end else if (have && ridx >= RCW'(MAX_RECORDS)) begin
            wk_status <= ST_FULL;
          end else if (have && !rvalid[RW'(ridx)]) begin
            slot <= RW'(ridx);
            bl <= (best_left > AW'(NODE_BYTES)) ? AW'(f_len - best_left) : f_len;
          end
        end
        S_COMMIT: begin
          if (!is_free) begin
            rvalid[slot] <= 1'b1;
            wk_addr <= 16'(f_start + pad_of(f_start));
            used <= used + bl;
            if (used + bl > peak) begin
              peak <= used + bl;
            end
            if (best_left <= AW'(NODE_BYTES)) begin
              seg_cnt <= seg_cnt - 1'b1;
            end
            sh <= CW'(found);
            shift_up <= 1'b0;
          end else if (!mprev && !mnext && seg_cnt >= CW'(MAX_SEGMENTS)) begin
            wk_status <= ST_FULL;
          end else begin
            rvalid[slot] <= 1'b0;
            used <= used - bl;
            if (mprev && mnext) begin
              seg_cnt <= seg_cnt - 1'b1;
              sh <= pos;
              shift_up <= 1'b0;
            end else if (!mprev && !mnext) begin
              seg_cnt <= seg_cnt + 1'b1;
              sh <= seg_cnt - 1'b1;
              shift_up <= 1'b1;
            end
          end
        end
        S_SHIFT_WR: begin
          sh <= shift_up ? sh - 1'b1 : sh + 1'b1;
        end
        S_RESULT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_status <= wk_status;
            res_addr <= wk_addr;
            res_used <= 17'(used);
            res_peak <= 17'(peak);
            res_count <= 7'(seg_cnt);
          end
        end
        default: ;
      endcase
    end
  end

`include "free_list_allocator_macros.svh"
  `FLA_ASSERT(a_used_le_peak, clk, rst, used <= peak, "used bytes exceed peak")
  `FLA_ASSERT(a_seg_cnt_range, clk, rst, seg_cnt <= CW'(MAX_SEGMENTS), "segment count overflow")
  `FLA_ASSERT(a_take_idle, clk, rst, cmd_take |-> state == S_IDLE, "command taken while busy")
endmodule

// ===== src/free_list_allocator.sv =====
// Free-list allocator: address-sorted free segments, first or best fit, coalescing
// on free. The block works on one word at a time and after reset first sets up the
// initial free segment. An allocate takes the command, waits for the first segment
// read, scans the segment table, scans the record table for a free slot, commits,
// moves later segments down one entry at a time when a whole segment is taken, and
// hands out the result. A free takes the command, searches the records, scans the
// segments, commits, and when it merges both neighbors or inserts a new segment
// ahead of later ones moves entries one at a time (then places the new segment).
// The single read port of each table memory makes every scan and move walk the
// tables entry by entry. Up to two request words queue in front, and one result
// word waits at the output.
module free_list_allocator
  import fla_pkg::*;
#(
  parameter int ARENA_BYTES  = ARENA_BYTES_DEF,
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int MAX_RECORDS  = MAX_RECORDS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int NODE_BYTES   = NODE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic        opcode,
  input  logic [16:0] request_size,
  input  logic [3:0]  align_log2,
  input  logic [15:0] free_address,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status,
  output logic [15:0] data_address,
  output logic [16:0] used_total,
  output logic [16:0] peak_total,
  output logic [6:0]  free_segment_count
);
  logic fit_policy;
  logic cmd_valid, cmd_take, res_valid;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_policy <= 1'b0;
    end else if (cfg_we) begin
      fit_policy <= cfg_wdata;
    end
  end

  fla_front #(.NODE_BYTES(NODE_BYTES)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .request_size(request_size), .align_log2(align_log2),
    .free_address(free_address), .cmd_valid(cmd_valid), .cmd(cmd),
    .cmd_take(cmd_take));

  fla_back #(
    .ARENA_BYTES(ARENA_BYTES), .MAX_SEGMENTS(MAX_SEGMENTS),
    .MAX_RECORDS(MAX_RECORDS), .HEADER_BYTES(HEADER_BYTES),
    .NODE_BYTES(NODE_BYTES)
  ) u_back (
    .clk(clk), .rst(rst), .fit_policy(fit_policy), .cmd_valid(cmd_valid),
    .cmd(cmd), .cmd_take(cmd_take), .res_valid(res_valid), .res_ready(pop),
    .res_status(status), .res_addr(data_address), .res_used(used_total),
    .res_peak(peak_total), .res_count(free_segment_count));

  assign empty = !res_valid;
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the free-list allocator: directed table, random traffic.
`timescale 1ns / 100ps

module testbench;
  import fla_pkg::*;

  localparam int ARENA   = 65536;
  localparam int NSEG    = 64;
  localparam int NREC    = 64;
  localparam int HDR     = 16;
  localparam int NODE    = 16;
  localparam int N_RAND  = 450;

  typedef struct packed {
    logic        op;
    logic [16:0] size;
    logic [3:0]  alog;
    logic [15:0] faddr;
  } request_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [15:0] addr;
    logic [16:0] used;
    logic [16:0] peak;
    logic [6:0]  nseg;
  } reply_t;

  typedef struct {
    request_t req;
    logic     known;
    reply_t   rep;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic push = 1'b0;
  logic opcode = 1'b0;
  logic [16:0] request_size = '0;
  logic [3:0] align_log2 = '0;
  logic [15:0] free_address = '0;
  logic pop = 1'b0;
  logic full, empty;
  logic [2:0] status;
  logic [15:0] data_address;
  logic [16:0] used_total, peak_total;
  logic [6:0] free_segment_count;

  free_list_allocator u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .push(push), .full(full), .opcode(opcode), .request_size(request_size),
    .align_log2(align_log2), .free_address(free_address),
    .empty(empty), .pop(pop), .status(status), .data_address(data_address),
    .used_total(used_total), .peak_total(peak_total),
    .free_segment_count(free_segment_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow allocator state.
  logic        policy;
  int unsigned seg_base[NSEG];
  int unsigned seg_len[NSEG];
  int unsigned seg_n;
  int unsigned blk_data[NREC];
  int unsigned blk_base[NREC];
  int unsigned blk_len[NREC];
  bit          blk_live[NREC];
  int unsigned used_bytes, peak_bytes;

  reply_t reply_q[$];
  int     errors = 0;
  bit     hold_pop = 1'b0;
  bit     done_stim = 1'b0;

  function automatic int unsigned header_pad(int unsigned base, int unsigned mask);
    return ((base + HDR + mask) & ~mask) - base;
  endfunction

  function automatic void seg_delete(int unsigned pos);
    for (int unsigned i = pos; i + 1 < seg_n; i++) begin
      seg_base[i] = seg_base[i + 1];
      seg_len[i] = seg_len[i + 1];
    end
    seg_n--;
  endfunction

  function automatic logic [2:0] allocate(int unsigned size, int unsigned alog,
                                          output int unsigned addr);
    int unsigned mask, need, left, best = 0, pad, slot, pick = 0;
    bit have = 0;
    addr = 0;
    if (alog < MIN_ALIGN_LOG2 || alog > MAX_ALIGN_LOG2 || size < NODE) return ST_BAD;
    mask = (1 << alog) - 1;
    for (int unsigned i = 0; i < seg_n; i++) begin
      need = size + header_pad(seg_base[i], mask);
      if (seg_len[i] < need) continue;
      left = seg_len[i] - need;
      if (!have || (policy && left < best)) begin
        have = 1; pick = i; best = left;
        if (!policy) break;
      end
    end
    if (!have) return ST_NOFIT;
    for (slot = 0; slot < NREC; slot++) if (!blk_live[slot]) break;
    if (slot >= NREC) return ST_FULL;
    pad = header_pad(seg_base[pick], mask);
    need = size + pad;
    blk_base[slot] = seg_base[pick];
    blk_data[slot] = seg_base[pick] + pad;
    if (best > NODE) begin
      blk_len[slot] = need;
      seg_base[pick] += need;
      seg_len[pick] = best;
    end else begin
      blk_len[slot] = seg_len[pick];
      seg_delete(pick);
    end
    blk_live[slot] = 1;
    used_bytes += blk_len[slot];
    if (used_bytes > peak_bytes) peak_bytes = used_bytes;
    addr = blk_data[slot];
    return ST_OK;
  endfunction

  function automatic logic [2:0] release_block(int unsigned addr);
    int unsigned r, pos = 0, bs, bl;
    bit nxt, prv;
    if (addr == 0) return ST_OK;
    for (r = 0; r < NREC; r++) if (blk_live[r] && blk_data[r] == addr) break;
    if (r >= NREC) return ST_NOTALLOC;
    bs = blk_base[r];
    bl = blk_len[r];
    while (pos < seg_n && seg_base[pos] < bs) pos++;
    nxt = pos < seg_n && bs + bl == seg_base[pos];
    prv = pos > 0 && seg_base[pos - 1] + seg_len[pos - 1] == bs;
    if (nxt && prv) begin
      seg_len[pos - 1] += bl + seg_len[pos];
      seg_delete(pos);
    end else if (prv) begin
      seg_len[pos - 1] += bl;
    end else if (nxt) begin
      seg_base[pos] = bs;
      seg_len[pos] += bl;
    end else begin
      if (seg_n >= NSEG) return ST_FULL;
      for (int unsigned i = seg_n; i > pos; i--) begin
        seg_base[i] = seg_base[i - 1];
        seg_len[i] = seg_len[i - 1];
      end
      seg_base[pos] = bs;
      seg_len[pos] = bl;
      seg_n++;
    end
    blk_live[r] = 0;
    used_bytes -= bl;
    return ST_OK;
  endfunction

  function automatic reply_t predict_reply(request_t q);
    reply_t p;
    int unsigned a = 0;
    if (q.op == OP_ALLOC) p.st = allocate(q.size, q.alog, a);
    else p.st = release_block(q.faddr);
    p.addr = a[15:0];
    p.used = used_bytes[16:0];
    p.peak = peak_bytes[16:0];
    p.nseg = seg_n[6:0];
    return p;
  endfunction

  function automatic int unsigned live_address();
    int unsigned picks[$];
    for (int i = 0; i < NREC; i++) if (blk_live[i]) picks.push_back(blk_data[i]);
    if (picks.size() == 0) return 0;
    return picks[$urandom_range(picks.size() - 1)];
  endfunction

  // Push stays high from one word to the next when no idle cycles are drawn.
  task automatic send_word(request_t q, logic known, reply_t rep);
    reply_t p;
    int gap;
    gap = $urandom_range(4);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    opcode <= q.op;
    request_size <= q.size;
    align_log2 <= q.alog;
    free_address <= q.faddr;
    do @(posedge clk); while (full);
    p = predict_reply(q);
    if (known && p != rep) begin
      errors++;
      if (errors <= 10) $display("table row disagrees with shadow: %p vs %p", rep, p);
    end
    reply_q.push_back(p);
  endtask

  task automatic drain_and_config(logic value);
    push <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    policy = value;
  endtask

  // Result side: a drawn number of idle cycles per word plus an optional long hold-off.
  initial begin
    reply_t got, want;
    int gap;
    gap = $urandom_range(4);
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) begin
        got = '{status, data_address, used_total, peak_total, free_segment_count};
        if (reply_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: %p", got);
        end else begin
          want = reply_q.pop_front();
          if (got != want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
          end
        end
        gap = $urandom_range(4);
      end
      if (rst || hold_pop) begin
        pop <= 1'b0;
      end else if (gap != 0) begin
        pop <= 1'b0;
        gap--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    row_t rows[$];
    request_t q;
    reply_t none;
    int unsigned a;
    none = '0;
    policy = 0; seg_n = 1; seg_base[0] = 0; seg_len[0] = ARENA;
    used_bytes = 0; peak_bytes = 0;
    foreach (blk_live[i]) blk_live[i] = 0;

    rows.push_back('{'{OP_FREE, 17'd0, 4'd0, 16'd0}, 1, '{ST_OK, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'd64, 4'd2, 16'hFFFF}, 1,
                     '{ST_BAD, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'd64, 4'd13, 16'd0}, 1,
                     '{ST_BAD, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'd15, 4'd3, 16'd0}, 1,
                     '{ST_BAD, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'h1FFFF, 4'd15, 16'd0}, 1,
                     '{ST_BAD, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'd65536, 4'd3, 16'd0}, 1,
                     '{ST_NOFIT, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_FREE, 17'd0, 4'd0, 16'd1234}, 1,
                     '{ST_NOTALLOC, 16'd0, 17'd0, 17'd0, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'd16, 4'd3, 16'd0}, 1,
                     '{ST_OK, 16'd16, 17'd32, 17'd32, 7'd1}});
    rows.push_back('{'{OP_ALLOC, 17'd100, 4'd12, 16'd0}, 0, none});
    rows.push_back('{'{OP_ALLOC, 17'd200, 4'd5, 16'd0}, 0, none});
    rows.push_back('{'{OP_FREE, 17'd0, 4'd0, 16'd16}, 0, none});
    rows.push_back('{'{OP_FREE, 17'd0, 4'd0, 16'd4096}, 0, none});
    rows.push_back('{'{OP_ALLOC, 17'd65000, 4'd3, 16'd0}, 0, none});
    rows.push_back('{'{OP_FREE, 17'h1FFFF, 4'hF, 16'hFFFF}, 0, none});

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    drain_and_config(1'b0);
    foreach (rows[i]) send_word(rows[i].req, rows[i].known, rows[i].rep);

    // Several phases, switching the fit policy between them.
    for (int phase = 0; phase < 4; phase++) begin
      drain_and_config(phase[0]);
      if (phase == 2) begin
        // Stall the reader long enough that the input side backs up.
        fork
          begin
            hold_pop = 1;
            repeat (2000) @(posedge clk);
            hold_pop = 0;
          end
        join_none
      end
      for (int n = 0; n < N_RAND / 4; n++) begin
        q.op = ($urandom_range(99) < 50) ? OP_ALLOC : OP_FREE;
        q.size = ($urandom_range(9) == 0) ? 17'($urandom) :
                 ($urandom_range(3) == 0) ? 17'($urandom_range(16, 4096)) :
                                            17'($urandom_range(16, 300));
        q.alog = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3, 12));
        a = live_address();
        q.faddr = ($urandom_range(9) == 0 || a == 0) ? 16'($urandom) : a[15:0];
        // Freeing most blocks keeps the segment table busy with merges.
        if (phase == 3 && n > 60) q.op = OP_FREE;
        send_word(q, 0, none);
      end
    end
    push <= 1'b0;
    wait (reply_q.size() == 0);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
